>>> sv/bbhp_pkg.sv
// Shared types and constants for the bicubic Bezier height patch unit.
// No dependencies.
package bbhp_pkg;

    localparam int COORD_W  = 16;
    localparam int HEIGHT_W = 16;
    localparam int FRAC_W   = 12;
    localparam int ONE_Q12  = 4096;
    localparam int WEIGHT_W = 17;
    localparam int TAPS     = 4;

    typedef logic [WEIGHT_W-1:0] weight_t;
    typedef weight_t weight_vec_t [TAPS];

    typedef enum logic
    {
        FUNC_WRITE = 1'b0,
        FUNC_QUERY = 1'b1
    } func_t;

endpackage

>>> sv/bbhp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bbhp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/bbhp_weight.sv
// Two-stage Bernstein weight generator for one axis (Q0.12 in, Q1.16 out).
// Depends on bbhp_pkg.
module bbhp_weight
    import bbhp_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [FRAC_W-1:0] t,
    output weight_vec_t       w
);

    logic [FRAC_W-1:0]   t_reg;
    logic [FRAC_W:0]     a_reg;
    logic [2*FRAC_W-1:0] tt_reg;
    logic [2*FRAC_W+1:0] aa_reg;
    logic [2*FRAC_W:0]   ta_reg;
    logic [FRAC_W:0]     a_next;
    logic [39:0]         e [TAPS];
    weight_vec_t         w_reg;

    assign a_next = (FRAC_W+1)'(ONE_Q12) - {1'b0, t};

    always_comb
    begin
        e[0] = 40'(aa_reg) * 40'(a_reg);
        e[1] = 40'(ta_reg) * 40'(a_reg) * 40'd3;
        e[2] = 40'(tt_reg) * 40'(a_reg) * 40'd3;
        e[3] = 40'(tt_reg) * 40'(t_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg  <= t;
            a_reg  <= a_next;
            tt_reg <= t * t;
            aa_reg <= a_next * a_next;
            ta_reg <= {1'b0, t} * a_next;
            for (int k = 0; k < TAPS; k++)
            begin
                // round Q4.36 to Q1.16
                w_reg[k] <= WEIGHT_W'((e[k] + 40'd524288) >> 20);
            end
        end
    end

    assign w = w_reg;

endmodule

>>> sv/bicubic_bezier_height_patch_unit.sv
// Top level of the bicubic Bezier height patch unit: grid store, patch select
// and weighted sum pipeline. Depends on bbhp_pkg, bbhp_ram and bbhp_weight.
//
// Takes one transaction per clock while in_stall is low. Each query returns
// one height; writes give no result. The seven register stages are:
// - the input register;
// - the registered read of the sixteen replicated grid banks (one per control
//   point, all written together), alongside the first weight multiply;
// - the second weight multiply;
// - the row products;
// - the row sums;
// - the column products;
// - the final sum with saturation.
// Stalling a valid result freezes every stage and is passed back as in_stall.
module bicubic_bezier_height_patch_unit
    import bbhp_pkg::*;
#(
    parameter int GRID_SIZE = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       func,
    input  logic signed [COORD_W-1:0]  pos_x,
    input  logic signed [COORD_W-1:0]  pos_y,
    input  logic [7:0]                 entry_index,
    input  logic signed [HEIGHT_W-1:0] entry_value,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [HEIGHT_W-1:0] height
);

    localparam int ENTRIES   = GRID_SIZE * GRID_SIZE;
    localparam int AW        = $clog2(ENTRIES);
    localparam int PATCH_MAX = (GRID_SIZE - 4) / 3;

    logic en;

    // stage 0: split coordinates and form the patch base address
    logic [2:0]        nx, ny;
    logic [FRAC_W-1:0] fx_next, fy_next;
    int                px, py;
    logic [AW-1:0]     base_next;

    always_comb
    begin
        nx      = pos_x[15] ? 3'd0 : pos_x[14:12];
        ny      = pos_y[15] ? 3'd0 : pos_y[14:12];
        fx_next = pos_x[15] ? '0 : pos_x[11:0];
        fy_next = pos_y[15] ? '0 : pos_y[11:0];
        px      = (int'(nx) > PATCH_MAX) ? PATCH_MAX : int'(nx);
        py      = (int'(ny) > PATCH_MAX) ? PATCH_MAX : int'(ny);
        base_next = AW'(3 * py * GRID_SIZE + 3 * px);
    end

    logic                       v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic                       out_valid_reg;
    func_t                      f1_reg;
    logic                       wok1_reg;
    logic [AW-1:0]              wa1_reg;
    logic signed [HEIGHT_W-1:0] wd1_reg;
    logic [AW-1:0]              base1_reg;
    logic [FRAC_W-1:0]          fx1_reg, fy1_reg;

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    // stage 1: grid banks, one per control point
    logic [HEIGHT_W-1:0] hraw [TAPS*TAPS];
    logic                ram_we, ram_re;

    assign ram_we = en && v1_reg && (f1_reg == FUNC_WRITE) && wok1_reg;
    assign ram_re = en && v1_reg && (f1_reg == FUNC_QUERY);

    for (genvar g = 0; g < TAPS * TAPS; g++)
    begin : g_bank
        bbhp_ram #(
            .WIDTH (HEIGHT_W),
            .DEPTH (ENTRIES)
        ) u_bank (
            .clk   (clk),
            .we    (ram_we),
            .waddr (wa1_reg),
            .wdata (wd1_reg),
            .re    (ram_re),
            .raddr (base1_reg + AW'((g / TAPS) * GRID_SIZE + (g % TAPS))),
            .rdata (hraw[g])
        );
    end

    weight_vec_t wx, wy;

    bbhp_weight u_wx (.clk(clk), .en(en), .t(fx1_reg), .w(wx));
    bbhp_weight u_wy (.clk(clk), .en(en), .t(fy1_reg), .w(wy));

    logic signed [HEIGHT_W-1:0]   h3_reg   [TAPS*TAPS];
    logic signed [2*HEIGHT_W+1:0] p4_reg   [TAPS*TAPS];
    logic signed [2*HEIGHT_W+3:0] row5_reg [TAPS];
    logic signed [53:0]           m6_reg   [TAPS];
    weight_vec_t                  wy4_reg, wy5_reg;
    logic signed [HEIGHT_W-1:0]   height_reg;
    logic signed [55:0]           total;
    logic signed [23:0]           q;
    logic signed [HEIGHT_W-1:0]   height_next;

    always_comb
    begin
        total = 56'sd2147483648;
        for (int j = 0; j < TAPS; j++)
        begin
            total = total + 56'(m6_reg[j]);
        end
        q = 24'(total >>> 32);
        if (q > 24'sd32767)
        begin
            height_next = 16'sd32767;
        end
        else if (q < -24'sd32768)
        begin
            height_next = -16'sd32768;
        end
        else
        begin
            height_next = 16'(q);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg && (f1_reg == FUNC_QUERY);
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            v6_reg        <= v5_reg;
            out_valid_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_reg    <= func_t'(func);
            wok1_reg  <= int'(entry_index) < ENTRIES;
            wa1_reg   <= AW'(entry_index);
            wd1_reg   <= entry_value;
            base1_reg <= base_next;
            fx1_reg   <= fx_next;
            fy1_reg   <= fy_next;
            for (int k = 0; k < TAPS * TAPS; k++)
            begin
                h3_reg[k] <= hraw[k];
                p4_reg[k] <= h3_reg[k] * $signed({1'b0, wx[k % TAPS]});
            end
            wy4_reg <= wy;
            wy5_reg <= wy4_reg;
            for (int j = 0; j < TAPS; j++)
            begin
                row5_reg[j] <= 36'(p4_reg[j*TAPS]) + 36'(p4_reg[j*TAPS+1])
                             + 36'(p4_reg[j*TAPS+2]) + 36'(p4_reg[j*TAPS+3]);
                m6_reg[j]   <= 54'(row5_reg[j] * $signed({1'b0, wy5_reg[j]}));
            end
            height_reg <= height_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign height    = height_reg;

endmodule

>>> sv/bbhp_checker.sv
// Port-level checks for the height patch unit, bound to the top level.
// Depends on bicubic_bezier_height_patch_unit.
module bbhp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        func,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] height
);

    // a held result keeps its value
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(height))
        else $error("result changed while stalled");

    // back-pressure only comes from a blocked output
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output stall");

    // a query with a free output must be followed by a valid result
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && func) ##1 !out_stall ##1 !out_stall ##1 !out_stall
        ##1 !out_stall ##1 !out_stall ##1 !out_stall |=> out_valid)
        else $error("query result missing");

endmodule

bind bicubic_bezier_height_patch_unit bbhp_checker u_bbhp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .height    (height)
);

>>> test/bicubic_bezier_height_patch_unit_tb.sv
// Testbench for bicubic_bezier_height_patch_unit: grid writes and height queries
// checked against a scoreboard that models the patch evaluation.
// Depends on bbhp_pkg and the unit under test.
`timescale 1ns / 100ps

module bicubic_bezier_height_patch_unit_tb;
    import bbhp_pkg::*;

    localparam int GRID_SIZE  = 16;
    localparam int GRID_CELLS = GRID_SIZE * GRID_SIZE;
    localparam int PATCH_LAST = (GRID_SIZE - 4) / 3;
    localparam int PIPE_DEPTH = 7;
    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_ITEMS = 570;

    class height_scoreboard;
        logic signed [HEIGHT_W-1:0] grid [GRID_CELLS];
        logic signed [HEIGHT_W-1:0] heights_due [$];
        int mismatches;
        int queries_checked;
        int writes_seen;

        function new();
            mismatches = 0;
            queries_checked = 0;
            writes_seen = 0;
            foreach (grid[k])
                grid[k] = '0;
        endfunction

        function void split(input int pos, output int patch, output int frac);
            patch = pos / ONE_Q12;
            frac = pos % ONE_Q12;
            if (frac < 0) frac = 0;
            if (patch > PATCH_LAST) patch = PATCH_LAST;
            if (patch < 0) patch = 0;
        endfunction

        function void blend(input int t, output longint w [TAPS]);
            longint tt;
            longint a;
            longint raw [TAPS];
            tt = t;
            a = ONE_Q12 - tt;
            raw[0] = a * a * a;
            raw[1] = 3 * tt * a * a;
            raw[2] = 3 * tt * tt * a;
            raw[3] = tt * tt * tt;
            for (int k = 0; k < TAPS; k++)
                w[k] = (raw[k] + (64'sd1 <<< 19)) >>> 20;
        endfunction

        function logic signed [HEIGHT_W-1:0] surface(input int x, input int y);
            int px, py, fx, fy;
            longint wx [TAPS];
            longint wy [TAPS];
            longint acc;
            longint q;
            split(x, px, fx);
            split(y, py, fy);
            blend(fx, wx);
            blend(fy, wy);
            acc = 0;
            for (int j = 0; j < TAPS; j++)
                for (int i = 0; i < TAPS; i++)
                    acc += longint'(grid[(3 * py + j) * GRID_SIZE + 3 * px + i])
                           * wx[i] * wy[j];
            acc += 64'sd1 <<< 31;
            q = acc >>> 32;
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
            return q[HEIGHT_W-1:0];
        endfunction

        function void note_input(func_t f, logic signed [COORD_W-1:0] x,
                                 logic signed [COORD_W-1:0] y, logic [7:0] idx,
                                 logic signed [HEIGHT_W-1:0] value);
            if (f == FUNC_WRITE)
            begin
                writes_seen++;
                if (idx < GRID_CELLS)
                    grid[idx] = value;
            end
            else
                heights_due.push_back(surface(x, y));
        endfunction

        function void check_height(logic signed [HEIGHT_W-1:0] actual);
            logic signed [HEIGHT_W-1:0] want;
            if (heights_due.size() == 0)
            begin
                $error("height: unexpected result %0d", actual);
                mismatches++;
                return;
            end
            want = heights_due.pop_front();
            queries_checked++;
            if (actual !== want)
            begin
                $error("height: expected %0d actual %0d", want, actual);
                mismatches++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic func = FUNC_WRITE;
    logic signed [COORD_W-1:0] pos_x = '0;
    logic signed [COORD_W-1:0] pos_y = '0;
    logic [7:0] entry_index = '0;
    logic signed [HEIGHT_W-1:0] entry_value = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [HEIGHT_W-1:0] height;

    height_scoreboard board = new();
    int cycle_count = 0;
    bit send_burst = 1'b0;
    bit drain_burst = 1'b0;

    bicubic_bezier_height_patch_unit #(.GRID_SIZE(GRID_SIZE)) dut (.*);

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("bicubic_bezier_height_patch_unit test failed");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            board.check_height(height);

    // Stall the output for a random number of cycles, then release for one.
    initial
    begin
        int hold;
        @(posedge rst_n);
        forever
        begin
            hold = drain_burst ? 0 : $urandom_range(0, 9);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
        end
    end

    task automatic send(func_t f, logic signed [COORD_W-1:0] x,
                        logic signed [COORD_W-1:0] y, logic [7:0] idx,
                        logic signed [HEIGHT_W-1:0] value);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        pos_x <= x;
        pos_y <= y;
        entry_index <= idx;
        entry_value <= value;
        do
            @(posedge clk);
        while (in_stall);
        board.note_input(f, x, y, idx, value);
    endtask

    task automatic query(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y);
        send(FUNC_QUERY, x, y, 8'($urandom), 16'($urandom));
    endtask

    task automatic store(logic [7:0] idx, logic signed [HEIGHT_W-1:0] value);
        send(FUNC_WRITE, 16'($urandom), 16'($urandom), idx, value);
    endtask

    function automatic logic signed [COORD_W-1:0] random_pos();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 5 * ONE_Q12 - 1));
            2: return 16'($urandom_range(0, 7) * ONE_Q12);
            default: return 16'($urandom_range(0, 4) * ONE_Q12 + ONE_Q12 - 1);
        endcase
    endfunction

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill the whole grid first so no query reads an unwritten entry.
        send_burst = 1'b1;
        for (int k = 0; k < GRID_CELLS; k++)
            store(8'(k), 16'sd32767);
        send_burst = 1'b0;

        // Flat maximum grid: weight rounding may push the sum past full scale.
        query(16'sh0800, 16'sh0800);
        query(16'sh4000, 16'sh4000);
        store(8'd0, -16'sd32768);
        store(8'd17, 16'sd0);
        store(8'd255, -16'sd32768);
        query(16'sh0000, 16'sh0000);
        query(16'sh7FFF, 16'sh7FFF);
        query(16'sh8000, 16'sh8000);
        query(16'sh8000, 16'sh7FFF);
        query(16'shF001, 16'sh0FFF);
        query(16'sh0FFF, 16'shFFFF);
        query(16'sh4FFF, 16'sh4FFF);
        query(16'sh3000, 16'sh5000);
        for (int k = 0; k < GRID_CELLS; k++)
            store(8'(k), 16'($urandom));
        query(16'sh1000, 16'sh2800);
        query(16'sh7000, 16'sh0000);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0)
            begin
                send_burst = ($urandom_range(0, 3) == 0);
                drain_burst = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 9) < 7)
                query(random_pos(), random_pos());
            else
                store(8'($urandom), $urandom_range(0, 7) == 0 ?
                      ($urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000) : 16'($urandom));
        end
        in_valid <= 1'b0;
        drain_burst = 1'b0;

        wait (board.heights_due.size() == 0);
        repeat (PIPE_DEPTH * 4) @(posedge clk);

        $display("Covered %0d grid writes and %0d checked height queries.",
                 board.writes_seen, board.queries_checked);
        if (board.mismatches == 0 && board.heights_due.size() == 0)
            $display("bicubic_bezier_height_patch_unit test passed");
        else
            $display("bicubic_bezier_height_patch_unit test failed");
        $finish;
    end

endmodule

>>> sim.f
sv/bbhp_pkg.sv
sv/bbhp_ram.sv
sv/bbhp_weight.sv
sv/bicubic_bezier_height_patch_unit.sv
sv/bbhp_checker.sv
test/bicubic_bezier_height_patch_unit_tb.sv
